FILE: rtl/curve_header_endian_decoder_assert.svh
// ----------------------------------------------------------------------------
// Curve header decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef CURVE_HEADER_ENDIAN_DECODER_ASSERT_SVH
`define CURVE_HEADER_ENDIAN_DECODER_ASSERT_SVH

// Antecedent true at an edge implies consequent at the same edge.
`define CHED_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent true at an edge implies a delayed consequent.
`define CHED_ASSERT_IMP2(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

FILE: rtl/ched_pkg.sv
// ----------------------------------------------------------------------------
// ched_pkg
// Types, type codes and size function for the curve header decoder.
// ----------------------------------------------------------------------------
package ched_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COMP_W  = 4;
  localparam int unsigned SIZE_W  = 22;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned TYPE_W  = 4;

  // Curve type codes (header bits 19:16)
  localparam logic [TYPE_W-1:0] TYPE_KEYED   = 4'd1;
  localparam logic [TYPE_W-1:0] TYPE_CONST   = 4'd2;
  localparam logic [TYPE_W-1:0] TYPE_EMPTY_A = 4'd3;
  localparam logic [TYPE_W-1:0] TYPE_WIDE    = 4'd4;
  localparam logic [TYPE_W-1:0] TYPE_PAIRED  = 4'd5;
  localparam logic [TYPE_W-1:0] TYPE_EMPTY_B = 4'd6;
  localparam logic [TYPE_W-1:0] TYPE_EMPTY_C = 4'd7;

  // Largest size any header can give
  localparam logic [SIZE_W-1:0] CURVE_BYTES_MAX = 22'd4194244;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SIZE_W-1:0] size_t;

  function automatic word_t swap_bytes(input word_t w);
    swap_bytes = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Payload size from type, point count and component count; 0 for an unknown type.
  function automatic size_t curve_size(input word_t hdr, input logic [COMP_W-1:0] comps);
    logic [COUNT_W-1:0]  n;
    logic [COUNT_W+4:0]  prod;
    size_t               sz;
    n    = hdr[15:0];
    prod = 21'(n) * 21'({1'b0, comps} + 5'd1);
    case (hdr[19:16])
      TYPE_KEYED:   sz = size_t'({prod, 2'b00}) + size_t'(4);
      TYPE_CONST:   sz = size_t'({comps, 2'b00}) + size_t'(4);
      TYPE_WIDE:    sz = size_t'({n, 3'b000}) + size_t'(32);
      TYPE_PAIRED:  sz = size_t'({n, 3'b000}) + size_t'(8);
      TYPE_EMPTY_A,
      TYPE_EMPTY_B,
      TYPE_EMPTY_C: sz = size_t'(4);
      default:      sz = '0;
    endcase
    curve_size = sz;
  endfunction

endpackage

FILE: rtl/curve_header_endian_decoder.sv
// ----------------------------------------------------------------------------
// curve_header_endian_decoder
// Decodes a four-byte curve header of unknown byte order.
// ----------------------------------------------------------------------------
// One header enters per clock: busy is never raised, so start may be held
// high every cycle. An item accepted at one edge is captured in the input
// register; the decode (marker check, type check, size multiply and the
// compare against bytes_left for both byte orders in parallel) runs between
// that register and the result register. out_valid goes high as the result register
// is loaded, and its result is taken while out_valid is high. The input and
// result registers are the only registers on the path; throughput 1 item
// per cycle, since the decode is short logic (one 16x5 size multiply per byte
// order) placed between them. The receiver cannot stall, so results are
// never held: each out_valid pulse must be taken in that cycle.
// ----------------------------------------------------------------------------
module curve_header_endian_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_raw_bytes,
  input  logic [3:0]  in_component_count,
  input  logic [31:0] in_bytes_left,
  output logic        out_valid,
  output logic        out_found,
  output logic [31:0] out_header_word,
  output logic [21:0] out_curve_bytes,
  output logic        out_is_big_endian
);

  // Input register
  logic              in_valid_r;
  ched_pkg::word_t   raw_r;
  logic [3:0]        comps_r;
  ched_pkg::word_t   avail_r;

  // Result register
  logic              out_valid_r;
  logic              found_r,  found_nxt;
  ched_pkg::word_t   hdr_r,    hdr_nxt;
  ched_pkg::size_t   size_r,   size_nxt;
  logic              big_r,    big_nxt;

  // Per-order decode
  ched_pkg::word_t   hdr_be, hdr_le;
  ched_pkg::size_t   size_be, size_le;
  logic              ok_be, ok_le;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      raw_r   <= in_raw_bytes;
      comps_r <= in_component_count;
      avail_r <= in_bytes_left;
    end
  end

  assign hdr_be  = raw_r;
  assign hdr_le  = ched_pkg::swap_bytes(raw_r);
  assign size_be = ched_pkg::curve_size(hdr_be, comps_r);
  assign size_le = ched_pkg::curve_size(hdr_le, comps_r);

  // Marker nibble match, type in 1..7, nonzero size that fits
  assign ok_be = (hdr_be[27:24] == comps_r)
                 && (hdr_be[19:16] >= ched_pkg::TYPE_KEYED)
                 && (hdr_be[19:16] <= ched_pkg::TYPE_EMPTY_C)
                 && (size_be != '0) && (32'(size_be) <= avail_r);
  assign ok_le = (hdr_le[27:24] == comps_r)
                 && (hdr_le[19:16] >= ched_pkg::TYPE_KEYED)
                 && (hdr_le[19:16] <= ched_pkg::TYPE_EMPTY_C)
                 && (size_le != '0) && (32'(size_le) <= avail_r);

  // Big-endian wins when both readings pass
  always_comb begin
    found_nxt = 1'b0;
    hdr_nxt   = '0;
    size_nxt  = '0;
    big_nxt   = 1'b0;
    if (ok_be) begin
      found_nxt = 1'b1;
      hdr_nxt   = hdr_be;
      size_nxt  = size_be;
      big_nxt   = 1'b1;
    end else if (ok_le) begin
      found_nxt = 1'b1;
      hdr_nxt   = hdr_le;
      size_nxt  = size_le;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      found_r <= found_nxt;
      hdr_r   <= hdr_nxt;
      size_r  <= size_nxt;
      big_r   <= big_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_header_word   = hdr_r;
  assign out_curve_bytes   = size_r;
  assign out_is_big_endian = big_r;

endmodule

FILE: rtl/ched_checker.sv
// ----------------------------------------------------------------------------
// ched_checker
// Port-level checks on the curve header decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "curve_header_endian_decoder_assert.svh"

module ched_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [3:0]  in_component_count,
  input logic [31:0] in_bytes_left,
  input logic        out_valid,
  input logic        out_found,
  input logic [31:0] out_header_word,
  input logic [21:0] out_curve_bytes,
  input logic        out_is_big_endian
);

  `CHED_ASSERT_IMP2(a_result_follows, clk, rst_n, start && !busy, out_valid, "item lost")
  `CHED_ASSERT_IMP2(a_no_spurious, clk, rst_n, !(start && !busy), !out_valid, "extra result")
  `CHED_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !out_found,
    (out_header_word == '0) && (out_curve_bytes == '0) && !out_is_big_endian,
    "miss not zeroed")
  `CHED_ASSERT_IMP(a_size_fits, clk, rst_n, out_valid && out_found,
    (out_curve_bytes != '0) && (out_curve_bytes <= ched_pkg::CURVE_BYTES_MAX)
      && (32'(out_curve_bytes) <= $past(in_bytes_left, 2)),
    "size out of range")
  `CHED_ASSERT_IMP(a_marker_match, clk, rst_n, out_valid && out_found,
    out_header_word[27:24] == $past(in_component_count, 2), "marker mismatch")

endmodule

bind curve_header_endian_decoder ched_checker u_ched_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_component_count (in_component_count),
  .in_bytes_left      (in_bytes_left),
  .out_valid          (out_valid),
  .out_found          (out_found),
  .out_header_word    (out_header_word),
  .out_curve_bytes    (out_curve_bytes),
  .out_is_big_endian  (out_is_big_endian)
);

FILE: tb/sv/curve_header_endian_decoder_tb.sv
// ----------------------------------------------------------------------------
// curve_header_endian_decoder_tb
// Drives raw four-byte curve headers into the decoder through the start/busy
// handshake and checks every out_valid strobe against a behavioral decode of
// both byte orders or a typed table result. A short table of corner headers
// runs first. Mostly well-formed random headers follow, in phases with different sender gaps.
// ----------------------------------------------------------------------------
module curve_header_endian_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycle budget for roughly 1330 items, with gaps in the sparse phase and drain
  // pauses between phases; the limit is many times what they need.
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned ITEMS_PER_PHASE  = 434;
  localparam int unsigned NUM_PHASES       = 3;
  localparam int unsigned DRAIN_CYCLES     = 6;

  // One decoded header, laid out like the result ports
  typedef struct packed {
    logic            found;
    ched_pkg::word_t header_word;
    ched_pkg::size_t curve_bytes;
    logic            big_endian;
  } decoded_t;

  // One row of the directed table. When typed is set, want holds the result
  // read straight off the spec; otherwise the predictor supplies it.
  typedef struct {
    ched_pkg::word_t raw;
    logic [3:0]      comps;
    ched_pkg::word_t avail;
    bit              typed;
    decoded_t        want;
  } header_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_raw_bytes       = '0;
  logic [3:0]  in_component_count = '0;
  logic [31:0] in_bytes_left      = '0;
  logic        out_valid;
  logic        out_found;
  logic [31:0] out_header_word;
  logic [21:0] out_curve_bytes;
  logic        out_is_big_endian;

  // Travels with the item so the scoreboard knows which expectation to queue
  bit          row_typed = 1'b0;
  decoded_t    row_want  = '0;

  decoded_t    headers_due[$];
  header_row_t corner_rows[$];
  int unsigned idle_pct   = 0;
  int unsigned errors     = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned n_items    = 0;
  int unsigned n_big      = 0;
  int unsigned n_little   = 0;
  int unsigned n_rejected = 0;

  curve_header_endian_decoder DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_raw_bytes      (in_raw_bytes),
    .in_component_count(in_component_count),
    .in_bytes_left     (in_bytes_left),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_header_word   (out_header_word),
    .out_curve_bytes   (out_curve_bytes),
    .out_is_big_endian (out_is_big_endian)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Byte size of a curve for one reading of the header. 32 bits is plenty:
  // the worst case (type 1, 65535 points, 15 comps) is 4194244 bytes.
  function automatic logic [31:0] curve_len(input ched_pkg::word_t hdr,
                                            input logic [3:0] comps);
    logic [31:0] n;
    logic [31:0] c;
    n = 32'(hdr[15:0]);
    c = 32'(comps);
    case (hdr[19:16])
      ched_pkg::TYPE_KEYED:   curve_len = 32'd4 + n * 32'd4 + n * c * 32'd4;
      ched_pkg::TYPE_CONST:   curve_len = 32'd4 + c * 32'd4;
      ched_pkg::TYPE_WIDE:    curve_len = 32'd32 + n * 32'd8;
      ched_pkg::TYPE_PAIRED:  curve_len = 32'd8 + n * 32'd8;
      ched_pkg::TYPE_EMPTY_A,
      ched_pkg::TYPE_EMPTY_B,
      ched_pkg::TYPE_EMPTY_C: curve_len = 32'd4;
      default:                curve_len = 32'd0;
    endcase
  endfunction

  // Try big-endian, then the byte-swapped word; first acceptable one wins.
  function automatic decoded_t decode_header(input ched_pkg::word_t raw,
                                             input logic [3:0] comps,
                                             input ched_pkg::word_t avail);
    decoded_t        res;
    ched_pkg::word_t hdr;
    logic [31:0]     len;
    res = '0;
    for (int pass = 0; pass < 2; pass++) begin
      hdr = (pass == 0) ? raw : {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
      len = curve_len(hdr, comps);
      if (!res.found && hdr[27:24] == comps &&
          hdr[19:16] >= ched_pkg::TYPE_KEYED && hdr[19:16] <= ched_pkg::TYPE_EMPTY_C &&
          len != 0 && len <= avail) begin
        res.found       = 1'b1;
        res.header_word = hdr;
        res.curve_bytes = len[21:0];
        res.big_endian  = (pass == 0);
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: queue an expectation on every accepted item, check each strobe
  // against the oldest one. Everything is sampled at the rising edge, so the
  // values seen are the ones the block registers on that edge.
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    decoded_t want;
    if (rst_n && start && !busy) begin
      headers_due.push_back(row_typed ? row_want
                            : decode_header(in_raw_bytes, in_component_count, in_bytes_left));
    end
    if (rst_n && out_valid) begin
      if (headers_due.size() == 0) begin
        $error("result with nothing expected: found=%0b header_word=0x%08h",
               out_found, out_header_word);
        errors++;
      end else begin
        want = headers_due.pop_front();
        n_items++;
        if (!want.found)         n_rejected++;
        else if (want.big_endian) n_big++;
        else                     n_little++;
        check_field("found",         32'(want.found),      32'(out_found));
        check_field("header_word",   want.header_word,     out_header_word);
        check_field("curve_bytes",   32'(want.curve_bytes), 32'(out_curve_bytes));
        check_field("is_big_endian", 32'(want.big_endian), 32'(out_is_big_endian));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, headers_due.size());
      $display("curve_header_endian_decoder_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Present one item. Gaps are drawn per cycle from idle_pct; during a gap the
  // payload ports carry junk with start low. Returns right after the edge
  // that accepted the item, so the next call's falling-edge drive replaces it.
  task automatic send_header(input ched_pkg::word_t raw, input logic [3:0] comps,
                             input ched_pkg::word_t avail,
                             input bit typed, input decoded_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start              <= 1'b0;
      in_raw_bytes       <= $urandom;
      in_component_count <= 4'($urandom);
      in_bytes_left      <= $urandom;
      @(negedge clk);
    end
    start              <= 1'b1;
    in_raw_bytes       <= raw;
    in_component_count <= comps;
    in_bytes_left      <= avail;
    row_typed          <= typed;
    row_want           <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold off until every queued result has come back
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (headers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_row(input ched_pkg::word_t raw, input logic [3:0] comps,
                         input ched_pkg::word_t avail,
                         input bit typed, input decoded_t want);
    header_row_t r;
    r.raw   = raw;
    r.comps = comps;
    r.avail = avail;
    r.typed = typed;
    r.want  = want;
    corner_rows.push_back(r);
  endtask

  // Random header, mostly well-formed so the size and fit checks get
  // exercised; some raw noise, wrong markers and odd types mixed in.
  task automatic random_header(output ched_pkg::word_t raw, output logic [3:0] comps,
                               output ched_pkg::word_t avail);
    int unsigned     pick;
    logic [3:0]      tnib;
    logic [3:0]      mark;
    logic [15:0]     n;
    ched_pkg::word_t hdr;
    logic [31:0]     len;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      raw   = $urandom;
      comps = 4'($urandom);
      avail = ($urandom_range(0, 1) == 0) ? ched_pkg::word_t'($urandom)
                                          : ched_pkg::word_t'($urandom_range(0, 512));
    end else begin
      comps = ($urandom_range(0, 99) < 60) ? 4'($urandom_range(3, 4)) : 4'($urandom);
      tnib  = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 7)) : 4'($urandom);
      mark  = ($urandom_range(0, 99) < 90) ? comps : 4'($urandom);
      pick  = $urandom_range(0, 99);
      if (pick < 70)      n = 16'($urandom_range(0, 31));
      else if (pick < 90) n = 16'($urandom);
      else if (pick < 95) n = 16'h0000;
      else                n = 16'hFFFF;
      hdr = {4'($urandom), mark, 4'($urandom), tnib, n};
      len = curve_len(hdr, comps);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        raw = hdr;
      end else if (pick < 90) begin
        raw = {hdr[7:0], hdr[15:8], hdr[23:16], hdr[31:24]};
      end else begin
        // make the swapped reading plausible as well
        raw = hdr;
        raw[3:0]  = comps;
        raw[11:8] = 4'($urandom_range(1, 7));
      end
      pick = $urandom_range(0, 99);
      if (pick < 35)      avail = len;
      else if (pick < 50) avail = len - 1;
      else if (pick < 80) avail = len + $urandom_range(1, 64);
      else if (pick < 90) avail = $urandom;
      else if (pick < 95) avail = '0;
      else                avail = '1;
    end
  endtask

  initial begin : stimulus
    decoded_t        none;
    decoded_t        widest;
    ched_pkg::word_t raw;
    logic [3:0]      comps;
    ched_pkg::word_t avail;
    none   = '0;
    widest = {1'b1, 32'h0F01FFFF, ched_pkg::CURVE_BYTES_MAX, 1'b1};

    // Corner headers. Typed results only where they are obvious.
    add_row(32'h00000000, 4'd0,  32'h00000000, 1, none);   // all zero, type 0
    add_row(32'hFFFFFFFF, 4'd15, 32'hFFFFFFFF, 1, none);   // type F both ways
    add_row(32'h0F01FFFF, 4'd15, 32'hFFFFFFFF, 1, widest); // largest curve
    add_row(32'h0F01FFFF, 4'd15, 32'd4194244,  1, widest); // fits exactly
    add_row(32'h0F01FFFF, 4'd15, 32'd4194243,  1, none);   // one byte short
    add_row(32'h04030000, 4'd4,  32'h00000000, 1, none);   // nothing available
    add_row(32'h04080001, 4'd4,  32'hFFFFFFFF, 1, none);   // type out of range
    add_row(32'h04010002, 4'd4,  32'd100,      0, none);   // keyed
    add_row(32'h03020123, 4'd3,  32'd16,       0, none);   // constant, count unused
    add_row(32'h04030000, 4'd4,  32'd4,        0, none);   // empty type A
    add_row(32'h04040001, 4'd4,  32'd40,       0, none);   // wide
    add_row(32'h04050003, 4'd4,  32'd32,       0, none);   // paired, exact fit
    add_row(32'h04050003, 4'd4,  32'd31,       0, none);   // paired, too big
    add_row(32'h04060000, 4'd4,  32'd4,        0, none);   // empty type B
    add_row(32'h04070000, 4'd4,  32'd4,        0, none);   // empty type C
    add_row(32'h04000005, 4'd4,  32'hFFFFFFFF, 0, none);   // type zero
    add_row(32'h04000103, 4'd3,  32'd1000,     0, none);   // little-endian only
    add_row(32'h04010304, 4'd4,  32'd10,       0, none);   // big too large, little fits
    add_row(32'h04010304, 4'd4,  32'hFFFFFFFF, 0, none);   // both fit, big wins
    add_row(32'h00030000, 4'd0,  32'd4,        0, none);   // zero components
    add_row(32'h19010001, 4'd9,  32'h0000FFFF, 0, none);   // count above four
    add_row(32'hF4070000, 4'd4,  32'd4,        0, none);   // marker high nibble set
    add_row(32'h04010000, 4'd4,  32'd4,        0, none);   // keyed with no points
    add_row(32'hA5A5A5A5, 4'd5,  32'h80000000, 0, none);   // patterned noise

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table, back to back
    idle_pct = 0;
    foreach (corner_rows[i])
      send_header(corner_rows[i].raw, corner_rows[i].comps, corner_rows[i].avail,
                  corner_rows[i].typed, corner_rows[i].want);
    drain();

    // Random phases: streaming, sparse sender, light gaps. The queue is
    // drained between phases so the sender also sees a fully idle block.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       idle_pct = 0;
        1:       idle_pct = 61;
        default: idle_pct = 7;
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        random_header(raw, comps, avail);
        send_header(raw, comps, avail, 1'b0, none);
      end
      drain();
    end

    $display("checked %0d headers: %0d big-endian, %0d little-endian, %0d rejected",
             n_items, n_big, n_little, n_rejected);
    $display("sender gaps of 0, 61 and 7 percent, with full drains between phases");
    if (errors == 0) begin
      $display("curve_header_endian_decoder_tb: PASS");
    end else begin
      $display("curve_header_endian_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ched_pkg.sv
rtl/curve_header_endian_decoder.sv
rtl/ched_checker.sv
tb/sv/curve_header_endian_decoder_tb.sv
